// ===== rtl/robi_pkg.sv =====
// shared constants for the ray against oriented box intersect unit
`default_nettype none
package robi_pkg;
  localparam int LANE_W    = 21;
  localparam int IN_W      = 464;
  localparam int OUT_W     = 24;
  localparam int LEN_W     = 21;
  localparam int DIR_EPS   = 274878;
  localparam int LDIR_W    = 44;
  localparam int D30_W     = 36;
  localparam int AXES      = 3;
  localparam int OFS_ORG   = 0;
  localparam int OFS_DIR   = 63;
  localparam int OFS_LEN   = 126;
  localparam int OFS_CTR   = 147;
  localparam int OFS_SIZE  = 210;
  localparam int OFS_ROT0  = 273;
endpackage
`default_nettype wire

// ===== rtl/robi_xform.sv =====
// unpack, rotate into box frame: three register stages
`default_nettype none
module robi_xform #(
  parameter int C = 21
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [robi_pkg::IN_W-1:0]  in_data,
  output logic                            out_valid,
  output logic signed [C+23:0]            lo_o [3],
  output logic signed [robi_pkg::LDIR_W-1:0] ld_o [3],
  output logic [C-1:0]                    sz_o [3],
  output logic [robi_pkg::LEN_W-1:0]      len_o
);
  import robi_pkg::*;
  localparam int PW = C + 22;
  localparam int LOW = C + 24;

  logic signed [C:0]        diff_r [3];
  logic signed [LANE_W-1:0] dir_r [3];
  logic signed [LANE_W-1:0] rot_r [3][3];
  logic [C-1:0]             sz0_r [3], sz1_r [3], sz2_r [3];
  logic [LEN_W-1:0]         len0_r, len1_r, len2_r;
  logic                     v0_r, v1_r, v2_r;
  logic signed [PW-1:0]     po_r [3][3];
  logic signed [41:0]       pd_r [3][3];
  logic signed [LOW-1:0]    lo_r [3];
  logic signed [LDIR_W-1:0] ld_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len0_r <= in_data[OFS_LEN +: LEN_W];
      len1_r <= len0_r;
      len2_r <= len1_r;
      for (int j = 0; j < 3; j++) begin
        diff_r[j] <= $signed({in_data[OFS_ORG + LANE_W*j + C - 1], in_data[OFS_ORG + LANE_W*j +: C]})
                   - $signed({in_data[OFS_CTR + LANE_W*j + C - 1], in_data[OFS_CTR + LANE_W*j +: C]});
        dir_r[j]  <= $signed(in_data[OFS_DIR + LANE_W*j +: LANE_W]);
        sz0_r[j]  <= in_data[OFS_SIZE + LANE_W*j +: C];
        sz1_r[j]  <= sz0_r[j];
        sz2_r[j]  <= sz1_r[j];
        for (int i = 0; i < 3; i++) begin
          rot_r[j][i] <= $signed(in_data[OFS_ROT0 + 63*j + LANE_W*i +: LANE_W]);
          po_r[i][j]  <= rot_r[j][i] * diff_r[j];
          pd_r[i][j]  <= rot_r[j][i] * dir_r[j];
        end
      end
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= LOW'(po_r[i][0]) + LOW'(po_r[i][1]) + LOW'(po_r[i][2]);
        ld_r[i] <= LDIR_W'(pd_r[i][0]) + LDIR_W'(pd_r[i][1]) + LDIR_W'(pd_r[i][2]);
      end
    end
  end

  assign out_valid = v2_r;
  assign len_o     = len2_r;
  assign lo_o      = lo_r;
  assign ld_o      = ld_r;
  assign sz_o      = sz2_r;
endmodule
`default_nettype wire

// ===== rtl/robi_prep.sv =====
// per axis slab numerators, divisor, zero direction and slab miss flags, quotient signs
`default_nettype none
module robi_prep #(
  parameter int C = 21
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [C+23:0]          lo_i [3],
  input  wire logic signed [robi_pkg::LDIR_W-1:0] ld_i [3],
  input  wire logic [C-1:0]                  sz_i [3],
  input  wire logic [robi_pkg::LEN_W-1:0]    len_i,
  output logic                               out_valid,
  output logic [C+35:0]                      num_o [6],
  output logic [robi_pkg::D30_W-1:0]         den_o [6],
  output logic [32:0]                        side_o
);
  import robi_pkg::*;
  localparam int LOW = C + 24;
  localparam int NSW = C + 14;
  localparam int NW  = C + 36;

  logic [NW-1:0]    num_r [6];
  logic [D30_W-1:0] den_r [6];
  logic [2:0]       zdir_r, zmiss_r, neg1_r, neg2_r;
  logic [LEN_W-1:0] len_r;
  logic             v_r;

  logic [2:0]        zdir, zmiss, neg1, neg2;
  logic [NSW-1:0]    mag1 [3], mag2 [3];
  logic [D30_W-1:0]  dmag [3];

  for (genvar i = 0; i < 3; i++) begin : g_ax
    logic signed [LDIR_W:0]  ldx, absd;
    logic signed [LOW-1:0]   h27;
    logic signed [NSW-1:0]   o16, h16, n1, n2;
    logic signed [D30_W:0]   dx;
    assign ldx  = {ld_i[i][LDIR_W-1], ld_i[i]};
    assign absd = ldx[LDIR_W] ? -ldx : ldx;
    assign zdir[i] = absd < $signed((LDIR_W+1)'(DIR_EPS));
    assign h27  = $signed({6'b0, sz_i[i], 18'b0});
    assign zmiss[i] = zdir[i] && (lo_i[i] < -h27 || lo_i[i] > h27);
    assign o16  = $signed({lo_i[i][LOW-1], lo_i[i][LOW-1:11]});
    assign h16  = $signed({7'b0, sz_i[i], 7'b0});
    assign n1   = -h16 - o16;
    assign n2   = h16 - o16;
    assign mag1[i] = n1[NSW-1] ? NSW'(-n1) : NSW'(n1);
    assign mag2[i] = n2[NSW-1] ? NSW'(-n2) : NSW'(n2);
    assign dx   = {ld_i[i][LDIR_W-1], ld_i[i][LDIR_W-1:8]};
    assign dmag[i] = dx[D30_W] ? D30_W'(-dx) : D30_W'(dx);
    assign neg1[i] = n1[NSW-1] ^ dx[D30_W];
    assign neg2[i] = n2[NSW-1] ^ dx[D30_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[2*i]   <= {mag1[i], 22'b0};
        num_r[2*i+1] <= {mag2[i], 22'b0};
        den_r[2*i]   <= dmag[i];
        den_r[2*i+1] <= dmag[i];
      end
      zdir_r  <= zdir;
      zmiss_r <= zmiss;
      neg1_r  <= neg1;
      neg2_r  <= neg2;
      len_r   <= len_i;
    end
  end

  assign out_valid = v_r;
  assign num_o     = num_r;
  assign den_o     = den_r;
  assign side_o    = {len_r, neg2_r, neg1_r, zmiss_r, zdir_r};
endmodule
`default_nettype wire

// ===== rtl/robi_div.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes
`default_nettype none
module robi_div #(
  parameter int LANES = 6,
  parameter int NW    = 57,
  parameter int DW    = 36,
  parameter int SW    = 33
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num_i [LANES],
  input  wire logic [DW-1:0] den_i [LANES],
  input  wire logic [SW-1:0] side_i,
  output logic               out_valid,
  output logic [NW-1:0]      quo_o [LANES],
  output logic [SW-1:0]      side_o
);
  logic [DW-1:0] rem_r [NW][LANES];
  logic [NW-1:0] num_r [NW][LANES];
  logic [NW-1:0] q_r   [NW][LANES];
  logic [DW-1:0] den_r [NW][LANES];
  logic [SW-1:0] side_r [NW];
  logic          v_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW-1:0] rem_s [LANES];
    logic [NW-1:0] num_s [LANES];
    logic [NW-1:0] q_s   [LANES];
    logic [DW-1:0] den_s [LANES];
    logic [SW-1:0] side_s;
    logic          v_s;
    if (k == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign rem_s[l] = '0;
        assign num_s[l] = num_i[l];
        assign q_s[l]   = '0;
        assign den_s[l] = den_i[l];
      end
      assign side_s = side_i;
      assign v_s    = in_valid;
    end else begin : g_next
      for (genvar l = 0; l < LANES; l++) begin : g_l
        assign rem_s[l] = rem_r[k-1][l];
        assign num_s[l] = num_r[k-1][l];
        assign q_s[l]   = q_r[k-1][l];
        assign den_s[l] = den_r[k-1][l];
      end
      assign side_s = side_r[k-1];
      assign v_s    = v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_s;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      assign trial = {rem_s[l], num_s[l][NW-1]};
      assign diff  = trial - {1'b0, den_s[l]};
      assign ge    = trial >= {1'b0, den_s[l]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          num_r[k][l] <= {num_s[l][NW-2:0], 1'b0};
          q_r[k][l]   <= {q_s[l][NW-2:0], ge};
          den_r[k][l] <= den_s[l];
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = q_r[NW-1][l];
  end
  assign side_o    = side_r[NW-1];
  assign out_valid = v_r[NW-1];
endmodule
`default_nettype wire

// ===== rtl/robi_resolve.sv =====
// signed slab bounds, interval merge, hit decision and output register
`default_nettype none
module robi_resolve #(
  parameter int NW = 57
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] quo_i [6],
  input  wire logic [32:0]   side_i,
  output logic               out_valid,
  output logic               hit_o,
  output logic [robi_pkg::LEN_W-1:0] dist_o
);
  import robi_pkg::*;
  localparam int TW = NW + 2;
  localparam logic signed [TW-1:0] T_INF = $signed({2'b01, {NW{1'b0}}});

  logic signed [TW-1:0] amin_r [3], amax_r [3];
  logic                 zmiss_r, v0_r, v1_r, hit_r;
  logic [LEN_W-1:0]     len_r, dist_r;

  logic [2:0] zdir, zmiss, neg1, neg2;
  assign zdir  = side_i[2:0];
  assign zmiss = side_i[5:3];
  assign neg1  = side_i[8:6];
  assign neg2  = side_i[11:9];

  logic signed [TW-1:0] amin [3], amax [3];
  for (genvar i = 0; i < 3; i++) begin : g_ax
    logic signed [TW-1:0] q1, q2, t1, t2;
    assign q1 = $signed({2'b00, quo_i[2*i]});
    assign q2 = $signed({2'b00, quo_i[2*i+1]});
    assign t1 = neg1[i] ? -q1 : q1;
    assign t2 = neg2[i] ? -q2 : q2;
    assign amin[i] = zdir[i] ? -T_INF : ((t1 > t2) ? t2 : t1);
    assign amax[i] = zdir[i] ? T_INF  : ((t1 > t2) ? t1 : t2);
  end

  logic signed [TW-1:0] tmin01, tmax01, tmin, tmax, lenx, hitd0, hitd;
  logic                 miss;
  always_comb begin
    tmin01 = (amin_r[0] > amin_r[1]) ? amin_r[0] : amin_r[1];
    tmin   = (tmin01 > amin_r[2]) ? tmin01 : amin_r[2];
    tmax01 = (amax_r[0] < amax_r[1]) ? amax_r[0] : amax_r[1];
    tmax   = (tmax01 < amax_r[2]) ? tmax01 : amax_r[2];
    lenx   = $signed({{(TW-LEN_W){1'b0}}, len_r});
    hitd0  = tmin[TW-1] ? tmax : tmin;
    hitd   = hitd0[TW-1] ? '0 : hitd0;
    miss   = zmiss_r || tmin > tmax || tmax[TW-1] || tmin > lenx
          || !(tmin > 0 || tmax > 0) || hitd > lenx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amin_r  <= amin;
      amax_r  <= amax;
      zmiss_r <= |zmiss;
      len_r   <= side_i[32:12];
      hit_r   <= !miss;
      dist_r  <= miss ? '0 : hitd[LEN_W-1:0];
    end
  end

  assign out_valid = v1_r;
  assign hit_o     = hit_r;
  assign dist_o    = dist_r;
endmodule
`default_nettype wire

// ===== rtl/ray_oriented_box_intersect_unit.sv =====
// top level: ray against oriented box slab test, fully pipelined
//
// channel  dir  word                                        handshake
// in_      in   origin,direction,length,center,size,rot0..2 tvalid/tready
// out_     out  hit, hit distance                           tvalid/tready
//
// one word accepted per cycle while the output is not stalled, one result per word, in order
// stages in order: transform, prep, bit-per-stage divider, resolve
// reset clears all stage valid bits, payload registers are not reset
// a stalled result holds the whole pipeline; in_tready = !out_tvalid | out_tready
`default_nettype none
module ray_oriented_box_intersect_unit #(
  parameter int COORD_BITS = 21
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // ray_origin, ray_direction, ray_length, box_center, box_size,
  // rotation_row_0, rotation_row_1, rotation_row_2, zero pad
  input  wire logic [robi_pkg::IN_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // hit, hit distance, zero pad
  output logic [robi_pkg::OUT_W-1:0]       out_tdata
);
  import robi_pkg::*;
  localparam int C   = COORD_BITS;
  localparam int NW  = C + 36;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic                     xf_v;
  logic signed [C+23:0]     xf_lo [3];
  logic signed [LDIR_W-1:0] xf_ld [3];
  logic [C-1:0]             xf_sz [3];
  logic [LEN_W-1:0]         xf_len;

  robi_xform #(.C(C)) u_xform (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid), .in_data(in_tdata),
    .out_valid(xf_v), .lo_o(xf_lo), .ld_o(xf_ld), .sz_o(xf_sz), .len_o(xf_len)
  );

  logic             pr_v;
  logic [NW-1:0]    pr_num [6];
  logic [D30_W-1:0] pr_den [6];
  logic [32:0]      pr_side;

  robi_prep #(.C(C)) u_prep (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(xf_v),
    .lo_i(xf_lo), .ld_i(xf_ld), .sz_i(xf_sz), .len_i(xf_len),
    .out_valid(pr_v), .num_o(pr_num), .den_o(pr_den), .side_o(pr_side)
  );

  logic          dv_v;
  logic [NW-1:0] dv_quo [6];
  logic [32:0]   dv_side;

  robi_div #(.LANES(6), .NW(NW), .DW(D30_W), .SW(33)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(pr_v),
    .num_i(pr_num), .den_i(pr_den), .side_i(pr_side),
    .out_valid(dv_v), .quo_o(dv_quo), .side_o(dv_side)
  );

  logic             hit;
  logic [LEN_W-1:0] hit_dist;

  robi_resolve #(.NW(NW)) u_resolve (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(dv_v),
    .quo_i(dv_quo), .side_i(dv_side),
    .out_valid(out_tvalid), .hit_o(hit), .dist_o(hit_dist)
  );

  assign out_tdata = {2'b00, hit_dist, hit};

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[21:1] == '0)
    else $error("miss with nonzero distance");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline stalled");
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// testbench for the ray against oriented box intersect unit: directed and random rays
`timescale 1ns / 100ps
module testbench;
  import robi_pkg::*;

  localparam int ONE_Q19    = 524288;
  localparam int HOLD_LEN   = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int LATENCY    = 70;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  typedef struct packed {
    logic        hit;
    logic [20:0] span;
  } hit_result_t;

  hit_result_t hit_queue[$];
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  hold_request = 0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  rays_sent = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  quiet_cycles = 0;

  ray_oriented_box_intersect_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint sx21(logic [20:0] v);
    return longint'($signed(v));
  endfunction

  function automatic hit_result_t slab_test(logic [IN_W-1:0] w);
    longint diff[3], dir[3], sz[3], lo[3], ld[3];
    longint rot[3][3];
    longint len, tmin, tmax, hitd, absd, h27, o16, d30, h16, t1, t2, tt;
    bit miss;
    hit_result_t r;
    len = longint'(w[OFS_LEN +: 21]);
    tmin = -(longint'(1) << 62);
    tmax = longint'(1) << 62;
    miss = 0;
    for (int j = 0; j < 3; j++) begin
      diff[j] = sx21(w[OFS_ORG + 21*j +: 21]) - sx21(w[OFS_CTR + 21*j +: 21]);
      dir[j] = sx21(w[OFS_DIR + 21*j +: 21]);
      sz[j] = longint'(w[OFS_SIZE + 21*j +: 21]);
      for (int i = 0; i < 3; i++)
        rot[j][i] = sx21(w[OFS_ROT0 + 63*j + 21*i +: 21]);
    end
    for (int i = 0; i < 3; i++) begin
      lo[i] = 0;
      ld[i] = 0;
      for (int j = 0; j < 3; j++) begin
        lo[i] += rot[j][i] * diff[j];
        ld[i] += rot[j][i] * dir[j];
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (!miss) begin
        absd = ld[i] < 0 ? -ld[i] : ld[i];
        if (absd < DIR_EPS) begin
          h27 = sz[i] * 262144;
          if (lo[i] < -h27 || lo[i] > h27) miss = 1;
        end else begin
          o16 = lo[i] >>> 11;
          d30 = ld[i] >>> 8;
          h16 = sz[i] * 128;
          t1 = ((-h16 - o16) * 4194304) / d30;
          t2 = ((h16 - o16) * 4194304) / d30;
          if (t1 > t2) begin
            tt = t1;
            t1 = t2;
            t2 = tt;
          end
          if (t1 > tmin) tmin = t1;
          if (t2 < tmax) tmax = t2;
          if (tmin > tmax || tmax < 0 || tmin > len) miss = 1;
        end
      end
    end
    if (!miss && !((tmin > 0 || tmax > 0) && tmin <= len && tmin <= tmax)) miss = 1;
    hitd = 0;
    if (!miss) begin
      hitd = tmin;
      if (hitd < 0) hitd = tmax;
      if (hitd < 0) hitd = 0;
      if (hitd > len) miss = 1;
    end
    r.hit = !miss;
    r.span = miss ? 21'd0 : hitd[20:0];
    return r;
  endfunction

  function automatic logic [62:0] pack3(int x, int y, int z);
    return {z[20:0], y[20:0], x[20:0]};
  endfunction

  function automatic logic [IN_W-1:0] ray_word(logic [62:0] org, logic [62:0] dir,
      int len, logic [62:0] ctr, logic [62:0] size,
      logic [62:0] r0, logic [62:0] r1, logic [62:0] r2);
    logic [IN_W-1:0] w;
    w = '0;
    w[OFS_ORG +: 63] = org;
    w[OFS_DIR +: 63] = dir;
    w[OFS_LEN +: 21] = len[20:0];
    w[OFS_CTR +: 63] = ctr;
    w[OFS_SIZE +: 63] = size;
    w[OFS_ROT0 +: 63] = r0;
    w[OFS_ROT0 + 63 +: 63] = r1;
    w[OFS_ROT0 + 126 +: 63] = r2;
    return w;
  endfunction

  task automatic send_ray(logic [IN_W-1:0] w);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    forever begin
      @(negedge clk);
      if (in_tready) begin
        hit_queue = {hit_queue, slab_test(w)};
        rays_sent++;
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  task automatic idle_sender();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (hit_queue.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_request || hold_left > 0) begin
      if (hold_request) begin
        hold_left = HOLD_LEN;
        hold_request = 0;
      end
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(negedge clk) begin
    hit_result_t want, got;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.hit = out_tdata[0];
      got.span = out_tdata[21:1];
      results_seen++;
      if (got.hit) hits_seen++;
      if (hit_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0d dist=%0d", got.hit, got.span);
      end else begin
        want = hit_queue.pop_front();
        if (got.hit !== want.hit || got.span !== want.span || out_tdata[OUT_W-1:22] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0d dist=%0d, got hit=%0d dist=%0d",
                     want.hit, want.span, got.hit, got.span);
        end
      end
    end
  end

  function automatic logic [IN_W-1:0] random_ray();
    int perm[3], sg[3], axis, tmp, k;
    logic [62:0] rows[3], dir, org, ctr, size;
    if ($urandom_range(99) < 25) begin
      return ray_word(63'({$urandom, $urandom}), 63'({$urandom, $urandom}), $urandom,
                      63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                      63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
                      63'({$urandom, $urandom}));
    end
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = perm[i];
      perm[i] = perm[k];
      perm[k] = tmp;
    end
    for (int i = 0; i < 3; i++) begin
      sg[i] = $urandom_range(1) ? ONE_Q19 : -ONE_Q19;
      rows[i] = '0;
      rows[i][21*perm[i] +: 21] = sg[i][20:0];
    end
    axis = $urandom_range(2);
    case ($urandom_range(2))
      0: begin
        dir = '0;
        tmp = $urandom_range(1) ? ONE_Q19 : -ONE_Q19;
        dir[21*axis +: 21] = tmp[20:0];
      end
      1: dir = pack3($urandom_range(1) ? 314573 : -314573,
                     $urandom_range(1) ? 419430 : -419430, 0);
      default: dir = pack3($urandom_range(600000) - 300000,
                           $urandom_range(600000) - 300000,
                           $urandom_range(600000) - 300000);
    endcase
    org = pack3($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                $urandom_range(32768) - 16384);
    ctr = pack3($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                $urandom_range(32768) - 16384);
    size = pack3($urandom_range(16384), $urandom_range(16384), $urandom_range(16384));
    return ray_word(org, dir, $urandom_range(1) ? 2097151 : $urandom_range(40000),
                    ctr, size, rows[0], rows[1], rows[2]);
  endfunction

  task automatic test_directed();
    logic [62:0] ix, iy, iz, dx;
    ix = pack3(ONE_Q19, 0, 0);
    iy = pack3(0, ONE_Q19, 0);
    iz = pack3(0, 0, ONE_Q19);
    dx = pack3(ONE_Q19, 0, 0);
    // box of size 512 at x=2560, ray from origin along +x
    send_ray(ray_word('0, dx, 4096, pack3(2560, 0, 0), pack3(512, 512, 512), ix, iy, iz));
    // origin inside: exit distance
    send_ray(ray_word(pack3(2560, 0, 0), dx, 4096, pack3(2560, 0, 0),
                      pack3(512, 512, 512), ix, iy, iz));
    // box behind the ray
    send_ray(ray_word('0, dx, 4096, pack3(-2560, 0, 0), pack3(512, 512, 512), ix, iy, iz));
    // too short to reach
    send_ray(ray_word('0, dx, 1000, pack3(2560, 0, 0), pack3(512, 512, 512), ix, iy, iz));
    // negative direction
    send_ray(ray_word('0, pack3(-ONE_Q19, 0, 0), 4096, pack3(-2560, 0, 0),
                      pack3(512, 512, 512), ix, iy, iz));
    // zero-direction axis, origin inside and outside that slab
    send_ray(ray_word(pack3(0, 100, 0), dx, 4096, pack3(2560, 0, 0),
                      pack3(512, 512, 512), ix, iy, iz));
    send_ray(ray_word(pack3(0, 300, 0), dx, 4096, pack3(2560, 0, 0),
                      pack3(512, 512, 512), ix, iy, iz));
    send_ray(ray_word(pack3(0, 256, 0), dx, 4096, pack3(2560, 0, 0),
                      pack3(512, 512, 512), ix, iy, iz));
    // zero direction vector never hits
    send_ray(ray_word(pack3(2560, 0, 0), '0, 4096, pack3(2560, 0, 0),
                      pack3(512, 512, 512), ix, iy, iz));
    // zero direction and the smallest nonzero direction, below and above the zero threshold
    send_ray(ray_word('0, pack3(0, 0, 0), 4096, '0, pack3(512, 512, 512), ix, iy, iz));
    send_ray(ray_word('0, pack3(1, 0, 0), 2097151, pack3(256, 0, 0),
                      pack3(512, 512, 512), ix, iy, iz));
    // rotated box, permuted axes
    send_ray(ray_word('0, pack3(314573, 419430, 0), 8192, pack3(1500, 2000, 0),
                      pack3(400, 200, 300), iy, iz, ix));
    send_ray(ray_word('0, dx, 4096, pack3(2560, 0, 0), pack3(512, 512, 512),
                      pack3(370727, 370727, 0), pack3(-370727, 370727, 0), iz));
    // ray starting on the box face and just outside it, zero length
    send_ray(ray_word(pack3(2304, 0, 0), dx, 0, pack3(2560, 0, 0),
                      pack3(512, 512, 512), ix, iy, iz));
    send_ray(ray_word(pack3(2300, 0, 0), dx, 0, pack3(2560, 0, 0),
                      pack3(512, 512, 512), ix, iy, iz));
    // field extremes
    send_ray('0);
    send_ray(ray_word('1, '1, 2097151, '1, '1, '1, '1, '1));
    send_ray(ray_word(pack3(-1048576, -1048576, -1048576), dx, 2097151,
                      pack3(1048575, 1048575, 1048575), '1, ix, iy, iz));
    send_ray(ray_word(pack3(1048575, 0, 0), pack3(-1048576, 0, 0), 2097151,
                      pack3(-1048576, 0, 0), pack3(2097151, 2097151, 2097151),
                      pack3(-1048576, 0, 0), iy, iz));
    send_ray(ray_word('0, dx, 2097151, '0, '0, ix, iy, iz));
    wait_drained();
  endtask

  task automatic test_random(int snd_pct, int rcv_pct, int count);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int n = 0; n < count; n++) send_ray(random_ray());
    wait_drained();
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_request = 1;
    for (int n = 0; n < 120; n++) send_ray(random_ray());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(19, 87, 300);
    test_random(87, 19, 300);
    test_random(0, 0, 300);
    test_backpressure();
    test_random(0, 0, 100);
    repeat (LATENCY) @(posedge clk);
    $display("covered %0d rays (%0d results, %0d hits): directed cases, random rays,",
             rays_sent, results_seen, hits_seen);
    $display("idle and stall mixes, a long output hold and full drains");
    if (mismatches == 0 && hit_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, hit_queue.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/robi_pkg.sv
rtl/robi_xform.sv
rtl/robi_prep.sv
rtl/robi_div.sv
rtl/robi_resolve.sv
rtl/ray_oriented_box_intersect_unit.sv
verif/testbench.sv
